// File: src/ceb_pkg.sv
// Shared types and constants for the coincidence event builder.
// Depends on nothing; every other file imports it.

package ceb_pkg;

   // Depth of the pending hit buffer; kept a power of two so the ring pointers wrap freely.
   localparam int MAX_LOOKAHEAD = 16;
   localparam int PEND_W        = $clog2(MAX_LOOKAHEAD);
   localparam int CNT_W         = $clog2(MAX_LOOKAHEAD + 1);

   // Field widths.
   localparam int CHAN_W = 8;
   localparam int TIME_W = 48;
   localparam int ENGY_W = 16;
   localparam int POS_W  = 4;
   localparam int SPAN_W = 5;

   // Largest usable span of one event.
   localparam int SPAN_CAP = (MAX_LOOKAHEAD < 16) ? MAX_LOOKAHEAD : 16;

   // Reset values of the configuration registers.
   localparam logic [TIME_W-1:0] WINDOW_RESET    = TIME_W'(100);
   localparam logic [SPAN_W-1:0] LOOKAHEAD_RESET = SPAN_W'(4);

   // Configuration register indexes.
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_TIME_WINDOW   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOOKAHEAD     = 1'b1;

   typedef enum logic [0:0] {
      OP_HIT   = 1'b0,
      OP_FLUSH = 1'b1
   } op_type;

   typedef struct packed {
      op_type              operation;
      logic [CHAN_W-1:0]   hit_channel;
      logic [TIME_W-1:0]   hit_time;
      logic [ENGY_W-1:0]   hit_energy;
   } req_type;

   typedef struct packed {
      logic [CHAN_W-1:0]   out_channel;
      logic [TIME_W-1:0]   out_time;
      logic [ENGY_W-1:0]   out_energy;
      logic [POS_W-1:0]    hit_position;
      logic                event_end;
   } rsp_type;

   // One stored hit.
   typedef struct packed {
      logic [CHAN_W-1:0]   channel;
      logic [TIME_W-1:0]   stamp;
      logic [ENGY_W-1:0]   energy;
   } hit_type;

   // Classified command handed from the front to the engine.
   typedef struct packed {
      logic                valid;
      logic                flush;
      hit_type             hit;
   } cmd_type;

   // Active configuration.
   typedef struct packed {
      logic [TIME_W-1:0]   time_window;
      logic [SPAN_W-1:0]   span;
   } cfg_type;

   typedef enum logic [1:0] {
      ENG_IDLE,
      ENG_START,
      ENG_SCAN
   } eng_state_type;

endpackage

// File: src/ceb_front.sv
// Front end: a two-entry request queue that classifies each beat into a command.
// Depends on ceb_pkg.

module ceb_front
   import ceb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_payload,
   output cmd_type cmd,
   input  logic    cmd_take
);

   req_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       do_push;
   logic       do_pop;
   req_type    head;

   assign req_full = (fill_ff == 2'd2);
   assign do_push  = req_push && !req_full;
   assign do_pop   = cmd_take && (fill_ff != 2'd0);
   assign head     = slot_ff[rd_ptr_ff];

   // Decode the oldest beat for the engine.
   always_comb begin
      cmd.valid       = (fill_ff != 2'd0);
      cmd.flush       = (head.operation == OP_FLUSH);
      cmd.hit.channel = head.hit_channel;
      cmd.hit.stamp   = head.hit_time;
      cmd.hit.energy  = head.hit_energy;
   end

   // Pointer and fill bookkeeping.
   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Queue storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= req_payload;
      end
   end

endmodule

// File: src/ceb_rsp_queue.sv
// Result queue: two entries that decouple the engine from the consumer.
// Depends on ceb_pkg.

module ceb_rsp_queue
   import ceb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    full,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_payload
);

   rsp_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       do_push;
   logic       do_pop;

   assign full        = (fill_ff == 2'd2);
   assign rsp_empty   = (fill_ff == 2'd0);
   assign rsp_payload = slot_ff[rd_ptr_ff];
   assign do_push     = push && !full;
   assign do_pop      = rsp_pop && !rsp_empty;

   // Pointer and fill bookkeeping.
   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: src/ceb_engine.sv
// Back end: pending hit ring and the event scan that emits coincident hits.
// Depends on ceb_pkg.

module ceb_engine
   import ceb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  cmd_type cmd,
   output logic    cmd_take,
   output logic    out_push,
   output rsp_type out_data,
   input  logic    out_full
);

   eng_state_type     state_ff, state_in;

   // Pending ring: entry k of the buffer lives at head + k.
   hit_type           pend_ff [MAX_LOOKAHEAD];
   logic [PEND_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              flush_ff, flush_in;

   // Per-event scan state.
   logic [CNT_W-1:0]  span_ff, span_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [PEND_W-1:0] last_ff, last_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [TIME_W-1:0] t0_ff, t0_in;
   hit_type           held_ff, held_in;

   logic              wr_en;
   logic [PEND_W-1:0] wr_idx;
   logic [CNT_W-1:0]  count_hit;
   logic [CNT_W-1:0]  count_close;
   logic [CNT_W-1:0]  span_cfg;
   logic [PEND_W-1:0] rd_idx;
   hit_type           rd_hit;
   logic [TIME_W-1:0] diff_fwd;
   logic [TIME_W-1:0] diff_bwd;
   logic [TIME_W-1:0] delta;
   logic              match;
   logic              scan_done;

   // Count after a hit beat: a full buffer drops the new hit.
   assign count_hit   = (count_ff < CNT_W'(MAX_LOOKAHEAD)) ? count_ff + 1'b1 : count_ff;
   assign count_close = count_ff - (CNT_W'(last_ff) + 1'b1);
   assign span_cfg    = CNT_W'(cfg.span);
   assign wr_idx      = head_ff + count_ff[PEND_W-1:0];
   assign wr_en       = (state_ff == ENG_IDLE) && cmd.valid && !cmd.flush
                        && (count_ff < CNT_W'(MAX_LOOKAHEAD));

   // One read port: the start hit in START, the scanned hit in SCAN.
   assign rd_idx = (state_ff == ENG_START) ? head_ff : head_ff + idx_ff[PEND_W-1:0];
   assign rd_hit = pend_ff[rd_idx];

   // Absolute time distance to the start hit, against the window.
   assign diff_fwd  = rd_hit.stamp - t0_ff;
   assign diff_bwd  = t0_ff - rd_hit.stamp;
   assign delta     = (rd_hit.stamp >= t0_ff) ? diff_fwd : diff_bwd;
   assign match     = (delta < cfg.time_window);
   assign scan_done = (idx_ff == span_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ENG_IDLE: begin
            if (cmd.valid) begin
               if (cmd.flush) begin
                  if (count_ff != '0) begin
                     state_in = ENG_START;
                  end
               end else if (count_hit >= span_cfg) begin
                  state_in = ENG_START;
               end
            end
         end
         ENG_START: begin
            state_in = ENG_SCAN;
         end
         ENG_SCAN: begin
            if (scan_done && !out_full) begin
               if (flush_ff && (count_close != '0)) begin
                  state_in = ENG_START;
               end else begin
                  state_in = ENG_IDLE;
               end
            end
         end
         default: begin
            state_in = ENG_IDLE;
         end
      endcase
   end

   // Outputs and datapath updates.
   always_comb begin
      cmd_take = 1'b0;
      out_push = 1'b0;
      head_in  = head_ff;
      count_in = count_ff;
      flush_in = flush_ff;
      span_in  = span_ff;
      idx_in   = idx_ff;
      last_in  = last_ff;
      pos_in   = pos_ff;
      t0_in    = t0_ff;
      held_in  = held_ff;

      out_data.out_channel  = held_ff.channel;
      out_data.out_time     = held_ff.stamp;
      out_data.out_energy   = held_ff.energy;
      out_data.hit_position = pos_ff;
      out_data.event_end    = scan_done;

      case (state_ff)
         ENG_IDLE: begin
            if (cmd.valid) begin
               cmd_take = 1'b1;
               if (cmd.flush) begin
                  flush_in = (count_ff != '0);
               end else begin
                  count_in = count_hit;
               end
            end
         end
         ENG_START: begin
            // Span is cut to what remains, which only matters during a flush.
            span_in = (count_ff < span_cfg) ? count_ff : span_cfg;
            idx_in  = CNT_W'(1);
            last_in = '0;
            pos_in  = '0;
            t0_in   = rd_hit.stamp;
            held_in = rd_hit;
         end
         ENG_SCAN: begin
            if (scan_done) begin
               if (!out_full) begin
                  out_push = 1'b1;
                  head_in  = head_ff + last_ff + 1'b1;
                  count_in = count_close;
                  if (!(flush_ff && (count_close != '0))) begin
                     flush_in = 1'b0;
                  end
               end
            end else if (match) begin
               if (!out_full) begin
                  out_push = 1'b1;
                  held_in  = rd_hit;
                  pos_in   = pos_ff + 1'b1;
                  last_in  = idx_ff[PEND_W-1:0];
                  idx_in   = idx_ff + 1'b1;
               end
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         default: begin
            flush_in = 1'b0;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ENG_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
         flush_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
         flush_ff <= flush_in;
      end
   end

   // Scan registers are loaded in START before use.
   always_ff @(posedge clock) begin
      span_ff <= span_in;
      idx_ff  <= idx_in;
      last_ff <= last_in;
      pos_ff  <= pos_in;
      t0_ff   <= t0_in;
      held_ff <= held_in;
   end

   // Pending hit storage.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         pend_ff[wr_idx] <= cmd.hit;
      end
   end

endmodule

// File: src/coincidence_event_builder.sv
// Top level of the coincidence event builder: configuration registers, front, engine, result queue.
// Depends on ceb_pkg, ceb_front, ceb_engine and ceb_rsp_queue.
//
//   channel   ports                            direction   beat accepted when
//   request   req_push, req_full, req_payload   in          req_push && !req_full
//   result    rsp_pop, rsp_empty, rsp_payload   out         rsp_pop && !rsp_empty
//   config    csr_write, csr_index, csr_wdata   in          csr_write
//
// A hit beat that closes no event is taken by the engine once it reaches the head of the
// request queue and the engine is idle. Closing an event passes through START and then SCAN,
// with one distance compare per scanned hit; a flush repeats that for every event still pending.
// Reset is synchronous and empties both queues and the pending buffer.
// A full result queue stalls the engine scan; the request queue holds two beats meanwhile.

module coincidence_event_builder
   import ceb_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  req_type              req_payload,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output rsp_type              rsp_payload,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [TIME_W-1:0]    csr_wdata
);

   logic [TIME_W-1:0] window_ff, window_in;
   logic [SPAN_W-1:0] lookahead_ff, lookahead_in;
   cfg_type           cfg;
   cmd_type           cmd;
   logic              cmd_take;
   logic              out_push;
   rsp_type           out_data;
   logic              out_full;

   // Register writes.
   always_comb begin
      window_in    = window_ff;
      lookahead_in = lookahead_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_TIME_WINDOW: window_in    = csr_wdata;
            CSR_LOOKAHEAD:   lookahead_in = csr_wdata[SPAN_W-1:0];
            default:         window_in    = window_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= WINDOW_RESET;
         lookahead_ff <= LOOKAHEAD_RESET;
      end else begin
         window_ff    <= window_in;
         lookahead_ff <= lookahead_in;
      end
   end

   // Zero lookahead acts as one; large values clamp to the buffer depth.
   always_comb begin
      cfg.time_window = window_ff;
      if (lookahead_ff == '0) begin
         cfg.span = SPAN_W'(1);
      end else if (lookahead_ff > SPAN_W'(SPAN_CAP)) begin
         cfg.span = SPAN_W'(SPAN_CAP);
      end else begin
         cfg.span = lookahead_ff;
      end
   end

   ceb_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_payload (req_payload),
      .cmd         (cmd),
      .cmd_take    (cmd_take)
   );

   ceb_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .cmd      (cmd),
      .cmd_take (cmd_take),
      .out_push (out_push),
      .out_data (out_data),
      .out_full (out_full)
   );

   ceb_rsp_queue u_rsp_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (out_push),
      .push_data   (out_data),
      .full        (out_full),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_payload (rsp_payload)
   );

endmodule

// File: src/ceb_checker.sv
// Port-level checks for the coincidence event builder, bound to the top level.
// Depends on ceb_pkg and coincidence_event_builder.

module ceb_checker
   import ceb_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_push,
   input logic                 req_full,
   input req_type              req_payload,
   input logic                 rsp_empty,
   input logic                 rsp_pop,
   input rsp_type              rsp_payload,
   input logic                 csr_write,
   input logic [CSR_IDX_W-1:0] csr_index,
   input logic [TIME_W-1:0]    csr_wdata
);

   // The result queue comes out of reset empty and the request queue not full.
   assert property (@(posedge clock) reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

   // A waiting result beat holds until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> !rsp_empty && $stable(rsp_payload))
      else $error("waiting result beat changed");

   // Within an event, a beat directly following a non-final beat carries the next position.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop && !rsp_payload.event_end) |=>
         rsp_empty || (rsp_payload.hit_position == $past(rsp_payload.hit_position) + 4'd1))
      else $error("hit position did not advance");

   // A beat directly following the last beat of an event starts a new event.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop && rsp_payload.event_end) |=>
         rsp_empty || (rsp_payload.hit_position == '0))
      else $error("new event does not start at position zero");

endmodule

bind coincidence_event_builder ceb_checker u_ceb_checker (.*);

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for coincidence_event_builder: a directed table, then random hits.
// Depends on ceb_pkg and the coincidence_event_builder RTL; holds its own event predictor.

module tb_top;
   import ceb_pkg::*;

   localparam int PERIOD        = 20;
   localparam int RESET_CYCLES  = 7;
   localparam int SETTLE_CYCLES = 64;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int PHASE_ITEMS   = 51;

   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

   // Per phase of the random part: idling percentages and the configuration used.
   localparam int SEND_IDLE [4] = '{0, 57, 0, 16};
   localparam int RECV_STALL [4] = '{0, 0, 57, 16};
   localparam logic [TIME_W-1:0] PHASE_WINDOW [4] = '{48'd200, TIME_MAX, 48'd300, 48'd60};
   localparam logic [TIME_W-1:0] PHASE_LOOKAHEAD [4] = '{48'd4, 48'd16, 48'd31, 48'd3};

   // A row of the directed table is either a beat or a register write.
   // For register writes the value travels in the stamp field.
   typedef enum logic [1:0] {
      ROW_ITEM,
      ROW_WINDOW,
      ROW_LOOKAHEAD
   } row_kind_type;

   // How the expected results of a beat are obtained.
   typedef enum logic [1:0] {
      EXP_PREDICT,
      EXP_NONE,
      EXP_ECHO
   } exp_mode_type;

   typedef struct packed {
      row_kind_type        kind;
      op_type              op;
      logic [CHAN_W-1:0]   chan;
      logic [TIME_W-1:0]   stamp;
      logic [ENGY_W-1:0]   energy;
      exp_mode_type        mode;
   } row_type;

   localparam int DIRECTED_ROWS = 32;
   localparam row_type DIRECTED [DIRECTED_ROWS] = '{
      // Nothing pending after reset, so a flush yields nothing.
      '{ROW_ITEM, OP_FLUSH, 8'hff, 48'h0, 16'h0, EXP_NONE},
      // Reset configuration: window 100, lookahead of four hits per event.
      '{ROW_ITEM, OP_HIT, 8'd1, 48'd1000, 16'd10, EXP_PREDICT},
      '{ROW_ITEM, OP_HIT, 8'd2, 48'd1050, 16'd20, EXP_PREDICT},
      '{ROW_ITEM, OP_HIT, 8'd3, 48'd5000, 16'd30, EXP_PREDICT},
      '{ROW_ITEM, OP_HIT, 8'd4, 48'd1099, 16'd40, EXP_PREDICT},
      // Differences of exactly the window stay out, one tick less joins.
      '{ROW_ITEM, OP_HIT, 8'd5, 48'd2000, 16'd50, EXP_PREDICT},
      '{ROW_ITEM, OP_HIT, 8'd6, 48'd2100, 16'd60, EXP_PREDICT},
      '{ROW_ITEM, OP_HIT, 8'd7, 48'd1900, 16'd70, EXP_PREDICT},
      '{ROW_ITEM, OP_HIT, 8'd8, 48'd1901, 16'd80, EXP_PREDICT},
      // Flush with a short remainder; its hit fields are ignored.
      '{ROW_ITEM, OP_HIT, 8'd9, 48'd3000, 16'd90, EXP_PREDICT},
      '{ROW_ITEM, OP_HIT, 8'd10, 48'd3001, 16'd100, EXP_PREDICT},
      '{ROW_ITEM, OP_FLUSH, 8'h00, TIME_MAX, 16'hffff, EXP_PREDICT},
      // One hit per event: every hit comes straight back.
      '{ROW_LOOKAHEAD, OP_HIT, 8'd0, 48'd1, 16'd0, EXP_PREDICT},
      '{ROW_ITEM, OP_HIT, 8'hff, TIME_MAX, 16'hffff, EXP_ECHO},
      '{ROW_ITEM, OP_HIT, 8'h00, 48'h0, 16'h0, EXP_ECHO},
      // A lookahead of zero behaves as one.
      '{ROW_LOOKAHEAD, OP_HIT, 8'd0, 48'd0, 16'd0, EXP_PREDICT},
      '{ROW_ITEM, OP_HIT, 8'h5a, 48'h5555_aaaa_5555, 16'ha5a5, EXP_ECHO},
      // Oversized lookahead is clamped; widest window, full-range time difference.
      '{ROW_LOOKAHEAD, OP_HIT, 8'd0, 48'd31, 16'd0, EXP_PREDICT},
      '{ROW_WINDOW, OP_HIT, 8'd0, TIME_MAX, 16'd0, EXP_PREDICT},
      '{ROW_ITEM, OP_HIT, 8'd11, 48'h0, 16'd1, EXP_PREDICT},
      '{ROW_ITEM, OP_HIT, 8'd12, TIME_MAX, 16'd2, EXP_PREDICT},
      '{ROW_ITEM, OP_HIT, 8'd13, 48'h1, 16'd3, EXP_PREDICT},
      '{ROW_ITEM, OP_FLUSH, 8'h33, 48'h1234, 16'h5678, EXP_PREDICT},
      // Zero window: nothing ever joins. Then the lookahead drops with hits pending.
      '{ROW_WINDOW, OP_HIT, 8'd0, 48'd0, 16'd0, EXP_PREDICT},
      '{ROW_LOOKAHEAD, OP_HIT, 8'd0, 48'd6, 16'd0, EXP_PREDICT},
      '{ROW_ITEM, OP_HIT, 8'd20, 48'd700, 16'd4, EXP_PREDICT},
      '{ROW_ITEM, OP_HIT, 8'd21, 48'd700, 16'd5, EXP_PREDICT},
      '{ROW_ITEM, OP_HIT, 8'd22, 48'd701, 16'd6, EXP_PREDICT},
      '{ROW_ITEM, OP_HIT, 8'd23, 48'd699, 16'd7, EXP_PREDICT},
      '{ROW_LOOKAHEAD, OP_HIT, 8'd0, 48'd2, 16'd0, EXP_PREDICT},
      '{ROW_ITEM, OP_HIT, 8'd24, 48'd700, 16'd8, EXP_PREDICT},
      '{ROW_ITEM, OP_FLUSH, 8'h00, 48'h0, 16'h0, EXP_PREDICT}
   };

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_push;
   logic                 req_full;
   req_type              req_payload;
   logic                 rsp_empty;
   logic                 rsp_pop = 1'b0;
   rsp_type              rsp_payload;
   logic                 csr_write;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [TIME_W-1:0]    csr_wdata;

   // Predictor state: pending hits and the active configuration.
   hit_type              pend_hits [MAX_LOOKAHEAD];
   int unsigned          pend_count;
   logic [TIME_W-1:0]    pred_window;
   logic [SPAN_W-1:0]    pred_lookahead;
   rsp_type              expected_hits [$];

   int                   error_count = 0;
   int                   cycle_count = 0;
   int                   sender_idle_pct = 0;
   int                   receiver_stall_pct = 0;
   logic [TIME_W-1:0]    hit_anchor = '0;

   coincidence_event_builder dut (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_payload (req_payload),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_payload (rsp_payload),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #(PERIOD / 2) clock = ~clock;

   // Span of one event after clamping the lookahead register.
   function automatic int unsigned event_span();
      int unsigned span;
      span = pred_lookahead;
      if (span < 1) span = 1;
      if (span > SPAN_CAP) span = SPAN_CAP;
      return span;
   endfunction

   // Close one event over the oldest hits, queue its hits, keep those after the last match.
   function automatic void close_event(int unsigned span);
      logic [MAX_LOOKAHEAD-1:0] joined;
      logic [TIME_W-1:0]        t0;
      logic [TIME_W-1:0]        delta;
      int unsigned              last;
      int unsigned              pos;
      int unsigned              k;
      rsp_type                  beat;
      if (span > pend_count) span = pend_count;
      if (span == 0) return;
      t0 = pend_hits[0].stamp;
      joined = 1;
      last = 0;
      for (int j = 1; j < span; j++) begin
         delta = (pend_hits[j].stamp >= t0) ? pend_hits[j].stamp - t0 : t0 - pend_hits[j].stamp;
         if (delta < pred_window) begin
            joined[j] = 1'b1;
            last = j;
         end
      end
      pos = 0;
      for (int j = 0; j <= last; j++) begin
         if (joined[j]) begin
            beat.out_channel  = pend_hits[j].channel;
            beat.out_time     = pend_hits[j].stamp;
            beat.out_energy   = pend_hits[j].energy;
            beat.hit_position = POS_W'(pos);
            beat.event_end    = (j == last);
            expected_hits.insert(expected_hits.size(), beat);
            pos++;
         end
      end
      k = 0;
      for (int j = last + 1; j < pend_count; j++) begin
         pend_hits[k] = pend_hits[j];
         k++;
      end
      pend_count = k;
   endfunction

   // Expected results of one accepted request beat.
   function automatic void predict_item(req_type item);
      int unsigned span;
      span = event_span();
      if (item.operation == OP_FLUSH) begin
         while (pend_count > 0) close_event(span < pend_count ? span : pend_count);
      end else begin
         if (pend_count < MAX_LOOKAHEAD) begin
            pend_hits[pend_count] = '{item.hit_channel, item.hit_time, item.hit_energy};
            pend_count++;
         end
         if (pend_count >= span) close_event(span);
      end
   endfunction

   function automatic void compare_field(string name, logic [TIME_W-1:0] want,
                                         logic [TIME_W-1:0] seen);
      if (seen !== want) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, seen);
         error_count++;
      end
   endfunction

   // Compare one result beat with the oldest expectation.
   function automatic void check_beat(rsp_type seen);
      rsp_type want;
      if (expected_hits.size() == 0) begin
         $error("result beat with nothing expected: channel 0x%0h, time 0x%0h",
                seen.out_channel, seen.out_time);
         error_count++;
         return;
      end
      want = expected_hits.pop_front();
      compare_field("out_channel", want.out_channel, seen.out_channel);
      compare_field("out_time", want.out_time, seen.out_time);
      compare_field("out_energy", want.out_energy, seen.out_energy);
      compare_field("hit_position", want.hit_position, seen.hit_position);
      compare_field("event_end", want.event_end, seen.event_end);
   endfunction

   // Hits cluster around a drifting anchor so that events form; some are scattered anywhere.
   function automatic req_type random_item();
      req_type     item;
      int unsigned spread;
      item.operation   = ($urandom_range(0, 19) == 0) ? OP_FLUSH : OP_HIT;
      item.hit_channel = CHAN_W'($urandom);
      item.hit_energy  = ENGY_W'($urandom);
      if ($urandom_range(0, 7) == 0) hit_anchor = TIME_W'({$urandom, $urandom});
      if (pred_window < 2000) spread = 2 * int'(pred_window[15:0]);
      else spread = 2000;
      if ($urandom_range(0, 4) == 0) begin
         item.hit_time = TIME_W'({$urandom, $urandom});
      end else begin
         item.hit_time = hit_anchor + TIME_W'($urandom_range(0, spread)) - TIME_W'(spread / 2);
      end
      return item;
   endfunction

   // Offer one request beat after a random gap and record what it should produce.
   task automatic send_item(input req_type item, input exp_mode_type mode);
      int unsigned gap;
      int unsigned queued;
      rsp_type     echo;
      gap = 0;
      while ($urandom_range(0, 99) < sender_idle_pct) gap++;
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push    <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_full) @(posedge clock);
      queued = expected_hits.size();
      predict_item(item);
      if (mode != EXP_PREDICT) begin
         // Typed-in expectation stands in for what the predictor queued.
         while (expected_hits.size() > queued) void'(expected_hits.pop_back());
         if (mode == EXP_ECHO) begin
            echo.out_channel  = item.hit_channel;
            echo.out_time     = item.hit_time;
            echo.out_energy   = item.hit_energy;
            echo.hit_position = POS_W'(0);
            echo.event_end    = 1'b1;
            expected_hits.insert(expected_hits.size(), echo);
         end
      end
   endtask

   // Registers change only once every expected beat is out and the engine has settled.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [TIME_W-1:0] value);
      req_push <= 1'b0;
      while (expected_hits.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_TIME_WINDOW) pred_window = value;
      else pred_lookahead = value[SPAN_W-1:0];
   endtask

   // Result side: check each accepted beat, then stall at random for the next one.
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) check_beat(rsp_payload);
      rsp_pop <= !reset && ($urandom_range(0, 99) >= receiver_stall_pct);
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Main sequence: reset, directed table, random phases, drain.
   initial begin
      row_type row;
      reset       = 1'b1;
      req_push    = 1'b0;
      req_payload = '0;
      csr_write   = 1'b0;
      csr_index   = CSR_TIME_WINDOW;
      csr_wdata   = '0;
      pend_count     = 0;
      pred_window    = WINDOW_RESET;
      pred_lookahead = LOOKAHEAD_RESET;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         row = DIRECTED[i];
         case (row.kind)
            ROW_WINDOW: begin
               write_csr(CSR_TIME_WINDOW, row.stamp);
            end
            ROW_LOOKAHEAD: begin
               write_csr(CSR_LOOKAHEAD, row.stamp);
            end
            default: begin
               send_item('{row.op, row.chan, row.stamp, row.energy}, row.mode);
            end
         endcase
      end

      for (int p = 0; p < 4; p++) begin
         write_csr(CSR_TIME_WINDOW, PHASE_WINDOW[p]);
         write_csr(CSR_LOOKAHEAD, PHASE_LOOKAHEAD[p]);
         sender_idle_pct    = SEND_IDLE[p];
         receiver_stall_pct = RECV_STALL[p];
         for (int n = 0; n < PHASE_ITEMS; n++) send_item(random_item(), EXP_PREDICT);
      end
      // Close whatever is still pending.
      send_item('{OP_FLUSH, 8'h00, 48'h0, 16'h0}, EXP_PREDICT);
      req_push <= 1'b0;

      while (expected_hits.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// File: filelist.f
src/ceb_pkg.sv
src/ceb_front.sv
src/ceb_rsp_queue.sv
src/ceb_engine.sv
src/coincidence_event_builder.sv
src/ceb_checker.sv
tb/tb_top.sv
